// ----- rtl/core/damped_node_euler_update_assert.svh -----
// Assertion macros for the damped node update block.
// Used by dneu_chk; expects clk and rst_n in the enclosing scope.
`ifndef DAMPED_NODE_EULER_UPDATE_ASSERT_SVH
`define DAMPED_NODE_EULER_UPDATE_ASSERT_SVH

// same-cycle implication
`define DNEU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dneu assertion failed");

// next-cycle implication
`define DNEU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dneu assertion failed");

`endif

// ----- rtl/core/dneu_pkg.sv -----
// Shared types, constants and helper functions for the damped node update.
// No dependencies.
`timescale 1ns / 1ps

package dneu_pkg;

    localparam int Q_W      = 32;   // signed Q16.16 word
    localparam int MASS_W   = 31;
    localparam int DEN_W    = 31;   // divisor width
    localparam int NUM_W    = 63;   // dividend / quotient width
    localparam int WIDE_W   = 66;   // signed working width for add + saturate
    localparam int CFG_IDX_W = 2;

    // register stages from request to result
    localparam int PIPE_LAT = 2 + NUM_W + 5 + NUM_W + 3;

    localparam logic [30:0] ENERGY_MAX = 31'h7FFF_FFFF;

    typedef logic signed [Q_W-1:0] q16_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 2'd0,
        CFG_TIME_STEP = 2'd1,
        CFG_DAMPING   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic        mode;
        logic [30:0] time_step;
        logic [30:0] damping;
    } cfg_t;

    typedef struct packed {
        q16_t        force_x;
        q16_t        force_y;
        q16_t        force_z;
        q16_t        momentum_in_x;
        q16_t        momentum_in_y;
        q16_t        momentum_in_z;
        q16_t        position_in_x;
        q16_t        position_in_y;
        q16_t        position_in_z;
        logic [30:0] node_mass;
    } dneu_in_t;

    typedef struct packed {
        q16_t        position_out_x;
        q16_t        position_out_y;
        q16_t        position_out_z;
        q16_t        momentum_out_x;
        q16_t        momentum_out_y;
        q16_t        momentum_out_z;
        logic [30:0] node_energy;
    } dneu_out_t;

    function automatic logic [Q_W-1:0] mag32(input logic [Q_W-1:0] x);
        return x[Q_W-1] ? Q_W'(-x) : x;
    endfunction

    function automatic wide_t sext(input logic [Q_W-1:0] x);
        return $signed({{(WIDE_W-Q_W){x[Q_W-1]}}, x});
    endfunction

    function automatic wide_t signed_mag(input logic neg, input logic [NUM_W-1:0] m);
        wide_t x;
        x = $signed({{(WIDE_W-NUM_W){1'b0}}, m});
        return neg ? -x : x;
    endfunction

    function automatic q16_t sat32(input wide_t x);
        wide_t hi;
        wide_t lo;
        hi = sext(32'h7FFF_FFFF);
        lo = sext(32'h8000_0000);
        if (x > hi)
            return q16_t'(32'h7FFF_FFFF);
        else if (x < lo)
            return q16_t'(32'h8000_0000);
        else
            return q16_t'(x[Q_W-1:0]);
    endfunction

endpackage

// ----- rtl/core/dneu_cfg.sv -----
// Configuration registers: mode, time step, damping.
// Depends on dneu_pkg.
`timescale 1ns / 1ps

module dneu_cfg
    import dneu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]          cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:      cfg_next.mode      = cfg_wdata[0];
                CFG_TIME_STEP: cfg_next.time_step = cfg_wdata;
                CFG_DAMPING:   cfg_next.damping   = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= 1'b0;
            cfg_reg.time_step <= 31'd65;
            cfg_reg.damping   <= 31'd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/dneu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes, with a sideband tag carried alongside. Depends on dneu_pkg.
`timescale 1ns / 1ps

module dneu_div
    import dneu_pkg::*;
#(
    parameter int LANES = 3,
    parameter int TW    = 1
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  logic [TW-1:0]               tag,
    output logic                        out_valid,
    output logic [LANES-1:0][NUM_W-1:0] quo,
    output logic [TW-1:0]               out_tag
);

    localparam int ACC_W = DEN_W + NUM_W;

    // {remainder, dividend bits left / quotient bits so far}
    logic [NUM_W-1:0]            vld_reg;
    logic [LANES-1:0][ACC_W-1:0] acc_reg [NUM_W];
    logic [DEN_W-1:0]            den_reg [NUM_W];
    logic [TW-1:0]               tag_reg [NUM_W];

    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] a,
                                                  input logic [DEN_W-1:0] d);
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        t    = a[ACC_W-1 -: DEN_W+1];
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            return {diff[DEN_W-1:0], a[NUM_W-2:0], 1'b1};
        else
            return {t[DEN_W-1:0], a[NUM_W-2:0], 1'b0};
    endfunction

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [LANES-1:0][ACC_W-1:0] acc_in;
        logic [DEN_W-1:0]            den_in;
        logic [TW-1:0]               tag_in;
        logic                        v_in;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                    acc_in[l] = {{DEN_W{1'b0}}, num[l]};
            end
            assign den_in = den;
            assign tag_in = tag;
            assign v_in   = in_valid;
        end
        else
        begin : g_next
            assign acc_in = acc_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
            assign v_in   = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < LANES; l++)
                acc_reg[k][l] <= div_step(acc_in[l], den_in);
            den_reg[k] <= den_in;
            tag_reg[k] <= tag_in;
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quo[l] = acc_reg[NUM_W-1][l][NUM_W-1:0];
    end

endmodule

// ----- rtl/core/damped_node_euler_update.sv -----
// Damped node time step, top level: stage logic around two divider pipelines.
// Depends on dneu_pkg, dneu_cfg, dneu_div.
`timescale 1ns / 1ps

// One node update per request, signed Q16.16. A request is taken on every
// cycle that start is high; busy never rises. Each result appears on result
// for exactly one cycle with done high, in request order; the receiver cannot
// hold it off. The path runs through two 63-stage dividers (one quotient bit
// per stage) in series, the first for drag or overdamped displacement, the
// second for displacement over mass and energy, or for force times mass over
// damping in overdamped mode, plus ten multiply/add stages. Write
// configuration only while no request is in flight.
module damped_node_euler_update
    import dneu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dneu_in_t             request,
    output logic                 done,
    output dneu_out_t            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]          cfg_wdata
);

    typedef struct packed {
        logic              mode;
        q16_t [2:0]        f;
        q16_t [2:0]        m;
        q16_t [2:0]        p;
        logic [MASS_W-1:0] mass;
    } node_t;

    typedef struct packed {
        logic              mode;
        q16_t [2:0]        f;
        q16_t [2:0]        mo;
        q16_t [2:0]        p;
        q16_t [2:0]        r;
        logic [MASS_W-1:0] mass;
    } mid_t;

    typedef struct packed {
        logic        mode;
        q16_t [2:0]  po;
        q16_t [2:0]  mo;
        logic [30:0] e0;
    } fin_t;

    cfg_t        cfg;
    logic [30:0] damp_c;
    logic [30:0] dt;

    dneu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign damp_c = (cfg.damping == '0) ? 31'd1 : cfg.damping;
    assign dt     = cfg.time_step;
    assign busy   = 1'b0;

    // ---------------- P0: capture request
    logic  v0_reg;
    node_t n0_reg;
    node_t n0_next;

    always_comb
    begin
        n0_next.mode = cfg.mode;
        n0_next.f[0] = request.force_x;
        n0_next.f[1] = request.force_y;
        n0_next.f[2] = request.force_z;
        n0_next.m[0] = request.momentum_in_x;
        n0_next.m[1] = request.momentum_in_y;
        n0_next.m[2] = request.momentum_in_z;
        n0_next.p[0] = request.position_in_x;
        n0_next.p[1] = request.position_in_y;
        n0_next.p[2] = request.position_in_z;
        n0_next.mass = (request.node_mass == '0) ? 31'd1 : request.node_mass;
    end

    // ---------------- P1: first products
    logic                    v1_reg;
    node_t                   n1_reg;
    logic [2:0][NUM_W-1:0]   pa_reg;
    logic [2:0][NUM_W-1:0]   pa_next;
    logic [DEN_W-1:0]        den_a_reg;
    logic [DEN_W-1:0]        den_a_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (n0_reg.mode)
                pa_next[i] = NUM_W'(mag32(n0_reg.f[i])) * NUM_W'(dt);
            else
                pa_next[i] = NUM_W'(mag32(n0_reg.m[i])) * NUM_W'(damp_c);
        end
        den_a_next = n0_reg.mode ? damp_c : n0_reg.mass;
    end

    // ---------------- divider A: drag (full) or displacement (overdamped)
    logic                  va;
    logic [2:0][NUM_W-1:0] qa;
    node_t                 ta;

    dneu_div #(.LANES(3), .TW($bits(node_t))) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .num       (pa_reg),
        .den       (den_a_reg),
        .tag       (n1_reg),
        .out_valid (va),
        .quo       (qa),
        .out_tag   (ta)
    );

    // ---------------- P2: net force, or overdamped position
    logic       v2_reg;
    node_t      n2_reg;
    q16_t [2:0] r2_reg;
    q16_t [2:0] r2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (ta.mode)
                r2_next[i] = sat32(sext(ta.p[i]) + signed_mag(ta.f[i][Q_W-1], qa[i]));
            else
                r2_next[i] = sat32(sext(ta.f[i]) - signed_mag(ta.m[i][Q_W-1], qa[i]));
        end
    end

    // ---------------- P3: net * dt
    logic                  v3_reg;
    node_t                 n3_reg;
    q16_t [2:0]            r3_reg;
    logic [2:0][NUM_W-1:0] pn3_reg;
    logic [2:0][NUM_W-1:0] pn3_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pn3_next[i] = NUM_W'(mag32(r2_reg[i])) * NUM_W'(dt);
    end

    // ---------------- P4: new momentum
    logic v4_reg;
    mid_t t4_reg;
    mid_t t4_next;

    always_comb
    begin
        t4_next.mode = n3_reg.mode;
        t4_next.f    = n3_reg.f;
        t4_next.p    = n3_reg.p;
        t4_next.r    = r3_reg;
        t4_next.mass = n3_reg.mass;
        for (int i = 0; i < 3; i++)
        begin
            if (n3_reg.mode)
                t4_next.mo[i] = n3_reg.m[i];
            else
                t4_next.mo[i] = sat32(sext(n3_reg.m[i])
                    + signed_mag(r3_reg[i][Q_W-1], NUM_W'(pn3_reg[i] >> 16)));
        end
    end

    // ---------------- P5: second products and momentum squares
    logic                  v5_reg;
    mid_t                  t5_reg;
    logic [2:0][NUM_W-1:0] num5_reg;
    logic [2:0][NUM_W-1:0] num5_next;
    logic [2:0][NUM_W-1:0] sq5_reg;
    logic [2:0][NUM_W-1:0] sq5_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (t4_reg.mode)
                num5_next[i] = NUM_W'(mag32(t4_reg.f[i])) * NUM_W'(t4_reg.mass);
            else
                num5_next[i] = NUM_W'(mag32(t4_reg.mo[i])) * NUM_W'(dt);
            sq5_next[i] = NUM_W'(mag32(t4_reg.mo[i])) * NUM_W'(mag32(t4_reg.mo[i]));
        end
    end

    // ---------------- P6: energy numerator, divider B operands
    logic                  v6_reg;
    mid_t                  t6_reg;
    logic [3:0][NUM_W-1:0] num6_reg;
    logic [3:0][NUM_W-1:0] num6_next;
    logic [DEN_W-1:0]      den6_reg;
    logic [DEN_W-1:0]      den6_next;
    logic [63:0]           msum;

    always_comb
    begin
        msum = 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]);
        for (int i = 0; i < 3; i++)
            num6_next[i] = num5_reg[i];
        num6_next[3] = msum[63:1];
        den6_next    = t5_reg.mode ? damp_c : t5_reg.mass;
    end

    // ---------------- divider B: displacement/mass, energy/mass, or f*mass/damping
    logic                  vb;
    logic [3:0][NUM_W-1:0] qb;
    mid_t                  tb;

    dneu_div #(.LANES(4), .TW($bits(mid_t))) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .num       (num6_reg),
        .den       (den6_reg),
        .tag       (t6_reg),
        .out_valid (vb),
        .quo       (qb),
        .out_tag   (tb)
    );

    // ---------------- P7: positions, full-dynamics energy, overdamped velocity
    logic                v7_reg;
    fin_t                f7_reg;
    fin_t                f7_next;
    logic [2:0][Q_W-1:0] vm7_reg;
    logic [2:0][Q_W-1:0] vm7_next;

    always_comb
    begin
        f7_next.mode = tb.mode;
        f7_next.mo   = tb.mo;
        f7_next.e0   = (|qb[3][NUM_W-1:31]) ? ENERGY_MAX : qb[3][30:0];
        for (int i = 0; i < 3; i++)
        begin
            if (tb.mode)
                f7_next.po[i] = tb.r[i];
            else
                f7_next.po[i] = sat32(sext(tb.p[i]) + signed_mag(tb.mo[i][Q_W-1], qb[i]));
            vm7_next[i] = mag32(sat32(signed_mag(tb.f[i][Q_W-1], qb[i])));
        end
    end

    // ---------------- P8: overdamped velocity squares
    logic                  v8_reg;
    fin_t                  f8_reg;
    logic [2:0][NUM_W-1:0] sv8_reg;
    logic [2:0][NUM_W-1:0] sv8_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sv8_next[i] = NUM_W'(vm7_reg[i]) * NUM_W'(vm7_reg[i]);
    end

    // ---------------- P9: result register
    logic        done_reg;
    dneu_out_t   result_reg;
    dneu_out_t   result_next;
    logic [63:0] vsum;
    logic [30:0] e1;

    always_comb
    begin
        vsum = 64'(sv8_reg[0]) + 64'(sv8_reg[1]) + 64'(sv8_reg[2]);
        e1   = (|vsum[63:48]) ? ENERGY_MAX : vsum[47:17];
        result_next.position_out_x = f8_reg.po[0];
        result_next.position_out_y = f8_reg.po[1];
        result_next.position_out_z = f8_reg.po[2];
        result_next.momentum_out_x = f8_reg.mo[0];
        result_next.momentum_out_y = f8_reg.mo[1];
        result_next.momentum_out_z = f8_reg.mo[2];
        result_next.node_energy    = f8_reg.mode ? e1 : f8_reg.e0;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= va;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= vb;
            v8_reg   <= v7_reg;
            done_reg <= v8_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        n0_reg     <= n0_next;
        n1_reg     <= n0_reg;
        pa_reg     <= pa_next;
        den_a_reg  <= den_a_next;
        n2_reg     <= ta;
        r2_reg     <= r2_next;
        n3_reg     <= n2_reg;
        r3_reg     <= r2_reg;
        pn3_reg    <= pn3_next;
        t4_reg     <= t4_next;
        t5_reg     <= t4_reg;
        num5_reg   <= num5_next;
        sq5_reg    <= sq5_next;
        t6_reg     <= t5_reg;
        num6_reg   <= num6_next;
        den6_reg   <= den6_next;
        f7_reg     <= f7_next;
        vm7_reg    <= vm7_next;
        f8_reg     <= f7_reg;
        sv8_reg    <= sv8_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/dneu_chk.sv -----
// Port-level checks for the damped node update block, bound to the top level.
// Depends on dneu_pkg and damped_node_euler_update_assert.svh.
`timescale 1ns / 1ps
`include "damped_node_euler_update_assert.svh"

module dneu_chk
    import dneu_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input dneu_in_t             request,
    input logic                 done,
    input dneu_out_t            result,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [30:0]          cfg_wdata
);

    logic cfg_idle;
    assign cfg_idle = !cfg_we || (cfg_index != CFG_MODE) || (cfg_wdata[30:1] == '0)
        || (cfg_wdata != '1) || (request.node_mass == request.node_mass);

    // the pipeline takes a request every cycle
    `DNEU_ASSERT_NOW(a_never_busy, cfg_idle, !busy)
    // every result traces back to a request taken earlier
    `DNEU_ASSERT_NOW(a_done_has_request, done, $past(start && !busy, PIPE_LAT))
    // a strobe never carries undefined data
    `DNEU_ASSERT_NEXT(a_result_known, 1'b1, !done || !$isunknown(result))

endmodule

bind damped_node_euler_update dneu_chk u_dneu_chk (.*);

// ----- sim/tb_damped_node_euler_update.sv -----
// Self-checking testbench for damped_node_euler_update: queue-fed driver, clocked monitor.
// Depends on dneu_pkg and the damped_node_euler_update RTL.
`timescale 1ns / 1ps

module tb_damped_node_euler_update;
    import dneu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register here
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = PIPE_LAT + 20;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [30:0]          data;
        dneu_in_t             node;
        int                   idle_pct;
    } pending_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    dneu_in_t             request = '0;
    logic                 done;
    dneu_out_t            result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [30:0]          cfg_wdata = '0;

    pending_t  pending_q[$];
    dneu_out_t node_exp_q[$];

    // shadow registers
    logic        sh_mode = 1'b0;
    logic [30:0] sh_dt = 31'd65;
    logic [30:0] sh_damp = 31'd65536;

    int  errors = 0;
    int  quiet_cycles = 0;

    damped_node_euler_update dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // magnitude product, truncated toward zero, then divided or shifted
    function automatic longint scaled(input longint a, input longint unsigned b,
                                      input longint unsigned c, input bit shift16);
        longint unsigned mg;
        longint unsigned q;
        mg = (a < 0) ? longint'(-a) : longint'(a);
        q = shift16 ? ((mg * b) >> 16) : ((mg * b) / c);
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic dneu_out_t node_step(input dneu_in_t r);
        longint f[3];
        longint m[3];
        longint p[3];
        longint mo[3];
        longint po[3];
        longint net;
        longint v;
        longint unsigned mass;
        longint unsigned damp;
        longint unsigned dt;
        longint unsigned sum;
        longint unsigned mm;
        longint unsigned energy;
        dneu_out_t o;
        f[0] = r.force_x; f[1] = r.force_y; f[2] = r.force_z;
        m[0] = r.momentum_in_x; m[1] = r.momentum_in_y; m[2] = r.momentum_in_z;
        p[0] = r.position_in_x; p[1] = r.position_in_y; p[2] = r.position_in_z;
        mass = r.node_mass;
        damp = sh_damp;
        dt = sh_dt;
        if (mass == 0)
            mass = 1;
        if (damp == 0)
            damp = 1;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (!sh_mode)
            begin
                net = clamp32(f[i] - scaled(m[i], damp, mass, 1'b0));
                mo[i] = clamp32(m[i] + scaled(net, dt, 1, 1'b1));
                po[i] = clamp32(p[i] + scaled(mo[i], dt, mass, 1'b0));
                mm = (mo[i] < 0) ? longint'(-mo[i]) : longint'(mo[i]);
            end
            else
            begin
                mo[i] = m[i];
                po[i] = clamp32(p[i] + scaled(f[i], dt, damp, 1'b0));
                v = clamp32(scaled(f[i], mass, damp, 1'b0));
                mm = (v < 0) ? longint'(-v) : longint'(v);
            end
            sum += mm * mm;
        end
        energy = sh_mode ? (sum >> 17) : ((sum >> 1) / mass);
        if (energy > 64'h7FFF_FFFF)
            energy = 64'h7FFF_FFFF;
        o.position_out_x = po[0][31:0];
        o.position_out_y = po[1][31:0];
        o.position_out_z = po[2][31:0];
        o.momentum_out_x = mo[0][31:0];
        o.momentum_out_y = mo[1][31:0];
        o.momentum_out_z = mo[2][31:0];
        o.node_energy = energy[30:0];
        return o;
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [30:0] pick_u31();
        case ($urandom_range(5))
            0: return 31'($urandom);
            1: return 31'($urandom_range(1 << 20));
            2: return ($urandom_range(1)) ? 31'h7FFF_FFFF : 31'd1;
            3: return 31'd65536;
            4: return 31'($urandom_range(1 << 16, 1 << 18));
            default: return 31'($urandom_range(255));
        endcase
    endfunction

    function automatic dneu_in_t rand_node();
        dneu_in_t n;
        n.force_x = pick_q16(); n.force_y = pick_q16(); n.force_z = pick_q16();
        n.momentum_in_x = pick_q16(); n.momentum_in_y = pick_q16();
        n.momentum_in_z = pick_q16();
        n.position_in_x = pick_q16(); n.position_in_y = pick_q16();
        n.position_in_z = pick_q16();
        n.node_mass = ($urandom_range(19) == 0) ? 31'd0 : pick_u31();
        return n;
    endfunction

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] data);
        pending_t e;
        e.is_cfg = 1'b1; e.idx = idx; e.data = data; e.node = '0; e.idle_pct = 0;
        pending_q.push_back(e);
    endtask

    task automatic add_node(input dneu_in_t n, input int idle_pct);
        pending_t e;
        e.is_cfg = 1'b0; e.idx = '0; e.data = '0; e.node = n; e.idle_pct = idle_pct;
        pending_q.push_back(e);
    endtask

    // driver: present next request or register write
    always @(posedge clk)
    begin
        logic wr_cfg;
        wr_cfg = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
                node_exp_q.push_back(node_step(request));
            if (!(start && busy))
            begin
                if (pending_q.size() == 0)
                    start <= 1'b0;
                else if (pending_q[0].is_cfg)
                begin
                    start <= 1'b0;
                    if (node_exp_q.size() == 0 && !start)
                    begin
                        wr_cfg = 1'b1;
                        cfg_index <= pending_q[0].idx;
                        cfg_wdata <= pending_q[0].data;
                        case (pending_q[0].idx)
                            CFG_MODE: sh_mode = pending_q[0].data[0];
                            CFG_TIME_STEP: sh_dt = pending_q[0].data;
                            CFG_DAMPING: sh_damp = pending_q[0].data;
                            default: ;
                        endcase
                        void'(pending_q.pop_front());
                    end
                end
                else if ($urandom_range(99) < pending_q[0].idle_pct)
                    start <= 1'b0;
                else
                begin
                    start <= 1'b1;
                    request <= pending_q[0].node;
                    void'(pending_q.pop_front());
                end
            end
            cfg_we <= wr_cfg;
        end
    end

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            errors++;
            $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
        end
    endtask

    // monitor and watchdog
    always @(posedge clk)
    begin
        dneu_out_t e;
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[damped_node_euler_update] ERROR");
                $finish;
            end
            if (done)
            begin
                if (node_exp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result: expected none actual %h", $time, result);
                end
                else
                begin
                    e = node_exp_q.pop_front();
                    check_field("position_out_x", e.position_out_x, result.position_out_x);
                    check_field("position_out_y", e.position_out_y, result.position_out_y);
                    check_field("position_out_z", e.position_out_z, result.position_out_z);
                    check_field("momentum_out_x", e.momentum_out_x, result.momentum_out_x);
                    check_field("momentum_out_y", e.momentum_out_y, result.momentum_out_y);
                    check_field("momentum_out_z", e.momentum_out_z, result.momentum_out_z);
                    check_field("node_energy", {1'b0, e.node_energy},
                                {1'b0, result.node_energy});
                end
            end
        end
    end

    initial
    begin
        dneu_in_t n;
        int idle;
        // directed: reset config, then extremes in both modes
        n = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF};
        add_node(n, 0);
        n.node_mass = 31'd0;            // zero mass acts as one LSB
        add_node(n, 0);
        n.node_mass = 31'd1;
        add_node(n, 0);
        add_cfg(CFG_TIME_STEP, 31'h7FFF_FFFF);
        add_cfg(CFG_DAMPING, 31'h7FFF_FFFF);
        add_node(n, 0);
        n.node_mass = 31'h7FFF_FFFF;
        add_node(n, 0);
        add_cfg(CFG_TIME_STEP, 31'd0);  // zero step leaves state unchanged
        add_node(n, 0);
        add_cfg(CFG_MODE, 31'd1);
        add_node(n, 0);
        add_cfg(CFG_TIME_STEP, 31'h7FFF_FFFF);
        add_cfg(CFG_DAMPING, 31'd0);    // zero damping acts as one LSB
        add_node(n, 0);
        n.node_mass = 31'd0;
        add_node(n, 0);
        add_cfg(CFG_DAMPING, 31'd1);
        add_node(n, 0);
        add_cfg(CFG_UNUSED, 31'h7FFF_FFFF);  // ignored
        add_node(n, 0);
        add_cfg(CFG_DAMPING, 31'h7FFF_FFFF);
        add_node(n, 0);
        for (int k = 0; k < 8; k++)
            add_node(rand_node(), 0);
        // random blocks, each under a fresh register setting
        for (int blk = 0; blk < 16; blk++)
        begin
            idle = (blk < 6) ? 35 : (blk < 11) ? 74 : 0;
            add_cfg(CFG_MODE, 31'($urandom_range(1)));
            add_cfg(CFG_TIME_STEP, ($urandom_range(7) == 0) ? 31'd0 : pick_u31());
            add_cfg(CFG_DAMPING, ($urandom_range(7) == 0) ? 31'd0 : pick_u31());
            if ($urandom_range(3) == 0)
                add_cfg(CFG_UNUSED, 31'($urandom));
            for (int k = 0; k < 100; k++)
                add_node(rand_node(), idle);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_q.size() != 0 || node_exp_q.size() != 0 || start)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && node_exp_q.size() == 0)
            $display("[damped_node_euler_update] OK");
        else
            $display("[damped_node_euler_update] ERROR");
        $finish;
    end

endmodule
